// ----- rtl/wpid_pkg.sv -----
// ----------------------------------------------------------------------------
// wpid_pkg
// shared widths, reset values, codes and state type of the windowed pid block
// ----------------------------------------------------------------------------
package wpid_pkg;

  // transaction field widths
  localparam int ERR_W      = 32;
  localparam int DT_W       = 31;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 31;
  localparam int CMD_W      = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // shared multiplier: gain times one 24 bit slice of a 48 bit term
  localparam int OP_W       = 48;
  localparam int HALF_W     = 24;
  localparam int MOPND_W    = HALF_W + 1;
  localparam int MPROD_W    = GAIN_W + MOPND_W;
  localparam int ACC_W      = 66;
  localparam int MSTEP_W    = 3;
  localparam int MSTEP_LAST = 5;

  // restoring divider: |diff| << 16 over the time step
  localparam int DIFF_W     = ERR_W + 1;
  localparam int FRAC_W     = 16;
  localparam int DIVD_W     = DIFF_W + FRAC_W;
  localparam int DIV_CNT_W  = 6;

  // derivative saturation magnitude, 2^47 - 1
  localparam logic [DIVD_W-1:0] D_SAT_MAG = DIVD_W'(48'h7FFF_FFFF_FFFF);

  // register reset values
  localparam logic signed [GAIN_W-1:0] P_GAIN_RST = 16'sd1792;
  localparam logic signed [GAIN_W-1:0] I_GAIN_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] D_GAIN_RST = 16'sd384;
  localparam logic [LIM_W-1:0]         LIMIT_RST  = 31'd196608;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN    = 2'd0,
    CFG_I_GAIN    = 2'd1,
    CFG_D_GAIN    = 2'd2,
    CFG_OUT_LIMIT = 2'd3
  } wpid_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DSETUP,
    ST_DIV,
    ST_DSAT,
    ST_MUL,
    ST_ACC,
    ST_WRITE,
    ST_FINISH
  } wpid_state_t;

endpackage

// ----- rtl/wpid_in_if.sv -----
// ----------------------------------------------------------------------------
// wpid_in_if
// sample channel: error sample, time step and flags with valid/ready
// ----------------------------------------------------------------------------
interface wpid_in_if
  import wpid_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] error_value;
  logic [DT_W-1:0]         time_step;
  logic                    time_ready;
  logic                    restart;

  modport source (
    output valid, error_value, time_step, time_ready, restart,
    input  ready
  );

  modport sink (
    input  valid, error_value, time_step, time_ready, restart,
    output ready
  );
endinterface

// ----- rtl/wpid_out_if.sv -----
// ----------------------------------------------------------------------------
// wpid_out_if
// result channel: clamped command with valid/ready
// ----------------------------------------------------------------------------
interface wpid_out_if
  import wpid_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] command;

  modport source (
    output valid, command,
    input  ready
  );

  modport sink (
    input  valid, command,
    output ready
  );
endinterface

// ----- rtl/wpid_ram.sv -----
// ----------------------------------------------------------------------------
// wpid_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wpid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/windowed_pid_controller.sv -----
// ----------------------------------------------------------------------------
// windowed_pid_controller
// run: a sample with the window inactive goes straight to the multiply steps;
//   otherwise the stored errors are summed, then the bit-serial divider runs
//   unless the time step is zero
// throughput: one sample at a time, ready again the cycle after the command
//   is loaded; the output register lets a command wait while the next runs
// reset: synchronous, clears the window count, sequencer and output valid,
//   loads the default gains and limit; the error ram is not cleared
// ----------------------------------------------------------------------------
module windowed_pid_controller
  import wpid_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  wpid_in_if.sink               sample,
  wpid_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  // sum of up to HISTORY_DEPTH errors, one spare bit
  localparam int INTEG_W = ERR_W + SLOT_W + 1;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_MIN   = CNT_W'(2);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] p_gain;
  logic signed [GAIN_W-1:0] i_gain;
  logic signed [GAIN_W-1:0] d_gain;
  logic [LIM_W-1:0]         output_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain       <= P_GAIN_RST;
      i_gain       <= I_GAIN_RST;
      d_gain       <= D_GAIN_RST;
      output_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (wpid_cfg_t'(cfg_index))
        CFG_P_GAIN:    p_gain       <= cfg_data[GAIN_W-1:0];
        CFG_I_GAIN:    i_gain       <= cfg_data[GAIN_W-1:0];
        CFG_D_GAIN:    d_gain       <= cfg_data[GAIN_W-1:0];
        CFG_OUT_LIMIT: output_limit <= cfg_data[LIM_W-1:0];
        default:       ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  wpid_state_t state, state_next;

  // sample held for the whole run
  logic signed [ERR_W-1:0] err;
  logic [DT_W-1:0]         dt;

  // window bookkeeping
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_inc;

  // window read sweep, newest first
  logic [SLOT_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]          issued;
  logic                      issue;
  logic                      rd_vld;
  logic                      rd_first;
  logic [ERR_W-1:0]          rdata;
  logic signed [ERR_W-1:0]   newest;
  logic signed [INTEG_W-1:0] integ;

  // divider
  logic                    neg;
  logic [DT_W-1:0]         rem;
  logic [DIVD_W-1:0]       quo;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic [DT_W:0]           rem_sh;
  logic [DT_W:0]           rem_sub;
  logic                    q_bit;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]       diff_mag;
  logic [OP_W-1:0]         d_mag;

  // derivative term
  logic signed [OP_W-1:0] deriv;
  logic signed [OP_W-1:0] err_ext;
  logic signed [OP_W-1:0] newest_ext;

  // shared multiplier and accumulator
  logic [MSTEP_W-1:0]        mstep;
  logic signed [GAIN_W-1:0]  gain_sel;
  logic signed [OP_W-1:0]    op_sel;
  logic signed [MOPND_W-1:0] op_half;
  logic signed [MPROD_W-1:0] mprod;
  logic signed [MPROD_W-1:0] prod;
  logic                      prod_hi;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc;

  // clamp and output register
  logic signed [ACC_W-1:0] lim_acc;
  logic signed [CMD_W-1:0] cmd;
  logic                    load;
  logic                    res_valid;
  logic signed [CMD_W-1:0] res_cmd;

  logic accept;
  logic ram_we;

  assign accept   = sample.valid && sample.ready;
  assign slot_inc = (slot == SLOT_LAST) ? '0 : slot + 1'b1;

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          // restart empties the window, so the terms stay zero
          if (!sample.restart && sample.time_ready && count >= CNT_MIN) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_SUM: begin
        if (issued == count && !rd_vld) begin
          state_next = ST_DSETUP;
        end
      end
      ST_DSETUP: begin
        state_next = (dt == '0) ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIVD_W - 1)) begin
          state_next = ST_DSAT;
        end
      end
      ST_DSAT:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_ACC;
      ST_ACC: begin
        state_next = (mstep == MSTEP_W'(MSTEP_LAST)) ? ST_WRITE : ST_MUL;
      end
      ST_WRITE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (!res_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    sample.ready = (state == ST_IDLE);
    issue        = (state == ST_SUM) && (issued != count);
    ram_we       = (state == ST_WRITE);
    load         = (state == ST_FINISH) && (!res_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // error window ram, read one entry a cycle, written once per sample
  // --------------------------------------------------------------------------
  wpid_ram #(
    .WIDTH (ERR_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_inc),
    .wdata (err),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // --------------------------------------------------------------------------
  // datapath combinational pieces
  // --------------------------------------------------------------------------
  always_comb begin
    err_ext    = {{(OP_W-ERR_W){err[ERR_W-1]}}, err};
    newest_ext = {{(OP_W-ERR_W){newest[ERR_W-1]}}, newest};

    diff     = {err[ERR_W-1], err} - {newest[ERR_W-1], newest};
    diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // one restoring divide step
    rem_sh  = {rem, quo[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, dt};
    q_bit   = (rem_sh >= {1'b0, dt});

    d_mag = (quo > D_SAT_MAG) ? OP_W'(D_SAT_MAG) : quo[OP_W-1:0];
  end

  // operand select: even steps take the low slice, odd steps the high slice
  always_comb begin
    unique case (mstep[MSTEP_W-1:1])
      2'd0: begin
        gain_sel = p_gain;
        op_sel   = err_ext;
      end
      2'd1: begin
        gain_sel = i_gain;
        op_sel   = {{(OP_W-INTEG_W){integ[INTEG_W-1]}}, integ};
      end
      2'd2: begin
        gain_sel = d_gain;
        op_sel   = deriv;
      end
      default: begin
        gain_sel = '0;
        op_sel   = '0;
      end
    endcase
    if (mstep[0]) begin
      op_half = {op_sel[OP_W-1], op_sel[OP_W-1:HALF_W]};
    end else begin
      op_half = {1'b0, op_sel[HALF_W-1:0]};
    end
    mprod = gain_sel * op_half;

    prod_ext = {{(ACC_W-MPROD_W){prod[MPROD_W-1]}}, prod};
    if (prod_hi) begin
      prod_ext = prod_ext <<< HALF_W;
    end
  end

  // symmetric clamp, otherwise floor of the q.24 sum down to q16.16
  always_comb begin
    lim_acc = {{(ACC_W-LIM_W-8){1'b0}}, output_limit, 8'b0};
    if (acc > lim_acc) begin
      cmd = {1'b0, output_limit};
    end else if (acc < -lim_acc) begin
      cmd = -$signed({1'b0, output_limit});
    end else begin
      cmd = acc[CMD_W+7:8];
    end
  end

  // --------------------------------------------------------------------------
  // window bookkeeping and output valid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      slot      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept && sample.restart) begin
        count <= '0;
        slot  <= '0;
      end else if (state == ST_WRITE) begin
        slot <= slot_inc;
        if (count != CNT_FULL) begin
          count <= count + 1'b1;
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        err     <= sample.error_value;
        dt      <= sample.time_step;
        rd_ptr  <= slot;
        issued  <= '0;
        rd_vld  <= 1'b0;
        integ   <= '0;
        deriv   <= '0;
        acc     <= '0;
        mstep   <= '0;
      end
      ST_SUM: begin
        rd_vld   <= issue;
        rd_first <= issue && (issued == '0);
        if (issue) begin
          issued <= issued + 1'b1;
          rd_ptr <= (rd_ptr == '0) ? SLOT_LAST : rd_ptr - 1'b1;
        end
        if (rd_vld) begin
          integ <= integ + {{(INTEG_W-ERR_W){rdata[ERR_W-1]}}, rdata};
          if (rd_first) begin
            newest <= rdata;
          end
        end
      end
      ST_DSETUP: begin
        if (dt == '0) begin
          // fallback: e - 60 * newest, as (newest << 6) - (newest << 2)
          deriv <= err_ext - (newest_ext <<< 6) + (newest_ext <<< 2);
        end
        neg     <= diff[DIFF_W-1];
        quo     <= {diff_mag, {FRAC_W{1'b0}}};
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem     <= q_bit ? rem_sub[DT_W-1:0] : rem_sh[DT_W-1:0];
        quo     <= {quo[DIVD_W-2:0], q_bit};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_DSAT: begin
        deriv <= neg ? -$signed(d_mag) : $signed(d_mag);
      end
      ST_MUL: begin
        prod    <= mprod;
        prod_hi <= mstep[0];
      end
      ST_ACC: begin
        acc   <= acc + prod_ext;
        mstep <= mstep + 1'b1;
      end
      ST_WRITE:  ;
      ST_FINISH: begin
        if (load) begin
          res_cmd <= cmd;
        end
      end
      default: ;
    endcase
  end

  assign result.valid   = res_valid;
  assign result.command = res_cmd;

endmodule

// ----- rtl/wpid_checker.sv -----
// ----------------------------------------------------------------------------
// wpid_checker
// port-level checks of the windowed pid block, bound to the top level
// ----------------------------------------------------------------------------
module wpid_checker
  import wpid_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_valid,
  input logic                    s_ready,
  input logic                    r_valid,
  input logic                    r_ready,
  input logic signed [CMD_W-1:0] r_command
);

  logic s_xact;

  assign s_xact = s_valid && s_ready;

  // a stalled command holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_command))
    else $error("stalled command changed or dropped");

  // one sample in flight: no transaction right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_xact |=> !s_xact)
    else $error("back to back sample transactions");

  // a new command appears only from the busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(r_valid) |-> !$past(s_ready))
    else $error("command appeared while sample port was idle");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("command valid after reset");

endmodule

bind windowed_pid_controller wpid_checker u_wpid_checker (
  .clk       (clk),
  .rst       (rst),
  .s_valid   (sample.valid),
  .s_ready   (sample.ready),
  .r_valid   (result.valid),
  .r_ready   (result.ready),
  .r_command (result.command)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the windowed pid controller: a scoreboard keeps its
// own error window, gains and clamp, predicts each command as samples are
// accepted and compares it with what the block returns, under random gaps,
// stalls and several gain and limit settings
// ----------------------------------------------------------------------------
module tb_top
  import wpid_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = 8;

  // --------------------------------------------------------------------------
  // scoreboard: command predictor plus queue of commands still owed
  // --------------------------------------------------------------------------
  class pid_scoreboard;
    logic signed [GAIN_W-1:0] kp, ki, kd;
    logic [LIM_W-1:0]         limit;
    logic signed [ERR_W-1:0]  window [WINDOW];
    int unsigned              fill;
    int unsigned              head;
    logic signed [CMD_W-1:0]  owed_cmds [$];
    int unsigned              n_fail;

    function new();
      // power-up gains 7.0, 0.0, 1.5 and a clamp of 3.0
      kp     = 16'sd1792;
      ki     = 16'sd0;
      kd     = 16'sd384;
      limit  = 31'd196608;
      fill   = 0;
      head   = 0;
      n_fail = 0;
      foreach (window[k]) window[k] = '0;
    endfunction

    function void set_reg(wpid_cfg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_P_GAIN:    kp = data[GAIN_W-1:0];
        CFG_I_GAIN:    ki = data[GAIN_W-1:0];
        CFG_D_GAIN:    kd = data[GAIN_W-1:0];
        CFG_OUT_LIMIT: limit = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_cmds.size();
    endfunction

    // one accepted sample transaction -> one predicted command
    function void note_sample(logic signed [ERR_W-1:0] err, logic [DT_W-1:0] dt,
                              logic tready, logic rstrt);
      longint integ, deriv, newest, total, lim24, cmd;
      longint sat;
      integ = 0;
      deriv = 0;
      sat   = 64'sd140737488355327;
      if (rstrt) begin
        fill = 0;
        head = 0;
      end
      if (fill >= 2 && tready) begin
        newest = window[head];
        for (int k = 0; k < fill; k++) integ += window[(head + WINDOW - k) % WINDOW];
        if (dt != 0) deriv = ((longint'(err) - newest) * 65536) / longint'(dt);
        else deriv = longint'(err) - 60 * newest;
        if (deriv > sat) deriv = sat;
        if (deriv < -sat) deriv = -sat;
      end
      head = (head + 1) % WINDOW;
      window[head] = err;
      if (fill < WINDOW) fill++;

      total = longint'(kp) * longint'(err) + longint'(ki) * integ + longint'(kd) * deriv;
      lim24 = longint'(limit) * 256;
      if (total > lim24) cmd = longint'(limit);
      else if (total < -lim24) cmd = -longint'(limit);
      else cmd = total >>> 8;
      owed_cmds.push_back(cmd[CMD_W-1:0]);
    endfunction

    function void check_command(logic signed [CMD_W-1:0] got);
      logic signed [CMD_W-1:0] want;
      if (owed_cmds.size() == 0) begin
        $error("command: expected none, actual %0d", got);
        n_fail++;
      end else begin
        want = owed_cmds.pop_front();
        if (got !== want) begin
          $error("command: expected %0d, actual %0d", want, got);
          n_fail++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wpid_in_if  sample_ch ();
  wpid_out_if result_ch ();

  pid_scoreboard sb = new();

  // receiver control: long hold request from the main flow, no-idle mode
  logic hold_req;
  logic steady;

  windowed_pid_controller #(
    .HISTORY_DEPTH(WINDOW)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net: the slowest legal run is far below this
  initial begin
    #15_000_000;
    $display("tb_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // gap lengths: mostly short, now and then long
  // --------------------------------------------------------------------------
  function automatic int send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 80);
  endfunction

  // --------------------------------------------------------------------------
  // result side: random back-pressure, plus one long hold counted here
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // long hold so the block fills up and stalls the sample side
        stall_left = 300;
        hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        result_ch.ready = 1'b0;
        stall_left = stall_len() - 1;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  // every accepted command transaction goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) sb.check_command(result_ch.command);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_sample(logic signed [ERR_W-1:0] err, logic [DT_W-1:0] dt,
                             logic tready, logic rstrt);
    int gap;
    gap = send_gap();
    repeat (gap) begin
      @(negedge clk);
      sample_ch.valid = 1'b0;
    end
    @(negedge clk);
    sample_ch.valid       = 1'b1;
    sample_ch.error_value = err;
    sample_ch.time_step   = dt;
    sample_ch.time_ready  = tready;
    sample_ch.restart     = rstrt;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(err, dt, tready, rstrt);
  endtask

  // register writes only happen with nothing in flight
  task automatic write_reg(wpid_cfg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_all(logic signed [GAIN_W-1:0] p, logic signed [GAIN_W-1:0] i,
                             logic signed [GAIN_W-1:0] d, logic [LIM_W-1:0] lim);
    // bits above a gain are don't-care, so fill them with noise
    write_reg(CFG_P_GAIN, {15'($urandom), p});
    write_reg(CFG_I_GAIN, {15'($urandom), i});
    write_reg(CFG_D_GAIN, {15'($urandom), d});
    write_reg(CFG_OUT_LIMIT, lim);
  endtask

  // sender pause until every owed command is back
  task automatic wait_for_results();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if (r < 30) return '0;
    if (r < 70) return GAIN_W'(int'($urandom_range(0, 2048)) - 1024);
    return GAIN_W'($urandom);
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 31'h7FFF_FFFF;
    if (r < 60) return LIM_W'($urandom_range(0, 1 << 22));
    return LIM_W'($urandom);
  endfunction

  // mostly well-formed control traffic: time known, few restarts
  task automatic random_sample();
    logic signed [ERR_W-1:0] err;
    logic [DT_W-1:0]         dt;
    int                      r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: err = 32'sh7FFF_FFFF;
        1: err = 32'sh8000_0000;
        2: err = '0;
        default: err = -32'sd1;
      endcase
    end else if (r < 55) begin
      err = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    end else begin
      err = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 10) dt = '0;
    else if (r < 20) dt = DT_W'($urandom);
    else if (r < 25) dt = $urandom_range(0, 1) ? 31'd1 : 31'h7FFF_FFFF;
    else dt = DT_W'($urandom_range(1, 1 << 18));
    send_sample(err, dt, $urandom_range(0, 9) != 0, $urandom_range(0, 29) == 0);
  endtask

  // --------------------------------------------------------------------------
  // main flow
  // --------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = CFG_P_GAIN;
    cfg_data              = '0;
    hold_req              = 1'b0;
    steady                = 1'b0;
    sample_ch.valid       = 1'b0;
    sample_ch.error_value = '0;
    sample_ch.time_step   = '0;
    sample_ch.time_ready  = 1'b0;
    sample_ch.restart     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // power-up gains and clamp, window filling from empty
    send_sample(32'sd65536, 31'd65536, 1'b1, 1'b0);
    send_sample(-32'sd131072, 31'd65536, 1'b1, 1'b0);
    send_sample(32'sd40000, 31'd0, 1'b1, 1'b0);
    wait_for_results();

    // unit-ish gains, wide clamp so every term shows up in the command
    program_all(16'sd256, 16'sd128, 16'sd64, 31'h7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF, 31'd65536, 1'b1, 1'b1);   // restart, empty window
    send_sample(32'sh8000_0000, 31'd65536, 1'b1, 1'b0);   // one stored error only
    send_sample(32'sh7FFF_FFFF, 31'd1, 1'b1, 1'b0);       // derivative clips high
    send_sample(32'sh8000_0000, 31'd1, 1'b1, 1'b0);       // derivative clips low
    send_sample(32'sd65536, 31'd0, 1'b1, 1'b0);           // zero step fallback
    send_sample(-32'sd65536, 31'h7FFF_FFFF, 1'b1, 1'b0);  // longest step
    send_sample(32'sd1000, 31'd65536, 1'b0, 1'b0);        // time not known yet
    for (int n = 0; n < 5; n++)                           // wrap the window
      send_sample(32'sd70000 * (n - 2), 31'd32768, 1'b1, 1'b0);
    send_sample(-32'sd5, 31'd65536, 1'b1, 1'b1);          // restart mid-stream
    send_sample(32'sd9, 31'd65536, 1'b1, 1'b0);
    send_sample(-32'sd77, 31'd0, 1'b1, 1'b0);
    wait_for_results();

    // clamp at both rails and floor rounding of negative sums
    program_all(16'sh7FFF, 16'sd0, 16'sd0, 31'd65536);
    send_sample(32'sh7FFF_FFFF, 31'd65536, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 31'd65536, 1'b0, 1'b0);
    send_sample(-32'sd1, 31'd65536, 1'b0, 1'b0);
    send_sample(32'sd1, 31'd65536, 1'b0, 1'b0);
    wait_for_results();
    program_all(16'sh8000, 16'sd0, 16'sd0, 31'd0);
    send_sample(32'sd12345, 31'd65536, 1'b1, 1'b0);
    wait_for_results();

    // random phases, each under its own setting
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) program_all(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 31'h7FFF_FFFF);
      else if (ph == 1) program_all(16'sh8000, 16'sh8000, 16'sh8000, 31'h7FFF_FFFF);
      else program_all(pick_gain(), pick_gain(), pick_gain(), pick_limit());
      steady = (ph == 4);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 120; n++) begin
        if (n == 60) wait_for_results();
        random_sample();
      end
      @(negedge clk);
      sample_ch.valid = 1'b0;
      wait_for_results();
    end

    // let any late command surface before deciding
    repeat (100) @(posedge clk);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wpid_pkg.sv
rtl/wpid_in_if.sv
rtl/wpid_out_if.sv
rtl/wpid_ram.sv
rtl/windowed_pid_controller.sv
rtl/wpid_checker.sv
verif/tb_top.sv
